// ===== rtl/core/acfp_pkg.sv =====
// shared types, constants and decode functions of the ascii can frame parser
package acfp_pkg;

   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

   localparam int unsigned ID_DIGITS_EXT = 8;
   localparam int unsigned ID_DIGITS_STD = 3;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_ID   = 4'b0010,
      PH_DLC  = 4'b0100,
      PH_DATA = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       bad;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [7:0]  frame_letter;
      logic        extended;
      logic [31:0] ident;
      logic [3:0]  dlc_code;
      logic [6:0]  payload_len;
      logic [5:0]  byte_index;
      logic [7:0]  data_byte;
      logic        has_data;
      logic        last;
      logic        bad_digit;
   } rsp_type;

   typedef struct packed {
      logic    emit;
      rsp_type beat;
   } parse_out_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.bad   = 1'b0;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else begin
         h.bad = 1'b1;
      end
      return h;
   endfunction

   // can fd dlc to byte count
   function automatic logic [6:0] dlc_len(input logic [3:0] dlc);
      logic [6:0] n;
      case (dlc)
         4'd9:    n = 7'd12;
         4'd10:   n = 7'd16;
         4'd11:   n = 7'd20;
         4'd12:   n = 7'd24;
         4'd13:   n = 7'd32;
         4'd14:   n = 7'd48;
         4'd15:   n = 7'd64;
         default: n = {3'b000, dlc};
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/core/acfp_if.sv =====
// valid/ready channel interfaces for characters in and parsed beats out
interface acfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface acfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_letter;
   logic        extended;
   logic [31:0] ident;
   logic [3:0]  dlc_code;
   logic [6:0]  payload_len;
   logic [5:0]  byte_index;
   logic [7:0]  data_byte;
   logic        has_data;
   logic        last;
   logic        bad_digit;

   modport source (output valid, output frame_letter, output extended, output ident,
                   output dlc_code, output payload_len, output byte_index,
                   output data_byte, output has_data, output last, output bad_digit,
                   input ready);
   modport sink   (input valid, input frame_letter, input extended, input ident,
                   input dlc_code, input payload_len, input byte_index,
                   input data_byte, input has_data, input last, input bad_digit,
                   output ready);
endinterface

// ===== rtl/core/acfp_parser.sv =====
// frame parse state and per-character next-state and beat logic
module acfp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            char_in,
   output acfp_pkg::parse_out_type result
);
   import acfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  digit_count_ff, digit_count_in;
   logic [31:0] ident_ff, ident_in;
   logic [7:0]  letter_ff, letter_in;
   logic        ext_ff, ext_in;
   logic [3:0]  dlc_ff, dlc_in;
   logic [5:0]  byte_count_ff, byte_count_in;
   logic [3:0]  high_ff, high_in;
   logic        pending_ff, pending_in;
   logic        err_ff, err_in;

   hex_type     hv;
   logic [6:0]  cur_len;
   logic [6:0]  next_idx;
   logic [3:0]  digits_need;

   always_comb begin
      hv          = hex_decode(char_in);
      cur_len     = dlc_len(dlc_ff);
      next_idx    = {1'b0, byte_count_ff} + 7'd1;
      digits_need = ext_ff ? 4'(ID_DIGITS_EXT) : 4'(ID_DIGITS_STD);

      phase_in       = phase_ff;
      digit_count_in = digit_count_ff;
      ident_in       = ident_ff;
      letter_in      = letter_ff;
      ext_in         = ext_ff;
      dlc_in         = dlc_ff;
      byte_count_in  = byte_count_ff;
      high_in        = high_ff;
      pending_in     = pending_ff;
      err_in         = err_ff;

      result.emit              = 1'b0;
      result.beat.frame_letter = letter_ff;
      result.beat.extended     = ext_ff;
      result.beat.ident        = ident_ff;
      result.beat.dlc_code     = dlc_ff;
      result.beat.payload_len  = cur_len;
      result.beat.byte_index   = 6'd0;
      result.beat.data_byte    = 8'd0;
      result.beat.has_data     = 1'b0;
      result.beat.last         = 1'b0;
      result.beat.bad_digit    = err_ff | hv.bad;

      unique case (phase_ff)
         PH_IDLE: begin
            if (char_in != CHAR_CR) begin
               letter_in      = char_in;
               ext_in         = (char_in > CHAR_UPPER_A) && (char_in < CHAR_UPPER_Z);
               ident_in       = 32'd0;
               digit_count_in = 4'd0;
               err_in         = 1'b0;
               dlc_in         = 4'd0;
               byte_count_in  = 6'd0;
               high_in        = 4'd0;
               pending_in     = 1'b0;
               phase_in       = PH_ID;
            end
         end
         PH_ID: begin
            ident_in       = {ident_ff[27:0], hv.value};
            err_in         = err_ff | hv.bad;
            digit_count_in = digit_count_ff + 4'd1;
            if (digit_count_in >= digits_need) begin
               phase_in = PH_DLC;
            end
         end
         PH_DLC: begin
            dlc_in         = hv.value;
            err_in         = err_ff | hv.bad;
            byte_count_in  = 6'd0;
            digit_count_in = 4'd0;
            pending_in     = 1'b0;
            if (dlc_len(hv.value) == 7'd0) begin
               result.emit             = 1'b1;
               result.beat.dlc_code    = hv.value;
               result.beat.payload_len = 7'd0;
               result.beat.last        = 1'b1;
               phase_in                = PH_IDLE;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            err_in = err_ff | hv.bad;
            if (!pending_ff) begin
               high_in    = hv.value;
               pending_in = 1'b1;
            end else begin
               pending_in             = 1'b0;
               result.emit            = 1'b1;
               result.beat.byte_index = byte_count_ff;
               result.beat.data_byte  = {high_ff, hv.value};
               result.beat.has_data   = 1'b1;
               result.beat.last       = next_idx >= cur_len;
               byte_count_in          = byte_count_ff + 6'd1;
               if (next_idx >= cur_len) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (!fire) begin
         result.emit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         digit_count_ff <= 4'd0;
         ident_ff       <= 32'd0;
         letter_ff      <= 8'd0;
         ext_ff         <= 1'b0;
         dlc_ff         <= 4'd0;
         byte_count_ff  <= 6'd0;
         high_ff        <= 4'd0;
         pending_ff     <= 1'b0;
         err_ff         <= 1'b0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         ident_ff       <= ident_in;
         letter_ff      <= letter_in;
         ext_ff         <= ext_in;
         dlc_ff         <= dlc_in;
         byte_count_ff  <= byte_count_in;
         high_ff        <= high_in;
         pending_ff     <= pending_in;
         err_ff         <= err_in;
      end
   end

endmodule

// ===== rtl/core/acfp_out_reg.sv =====
// result register holding one parsed beat until the sink takes it
module acfp_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  acfp_pkg::parse_out_type result,
   input  logic                    rsp_ready,
   output logic                    space,
   output logic                    rsp_valid,
   output acfp_pkg::rsp_type       rsp_beat
);
   import acfp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type beat_ff;

   always_comb begin
      space = !valid_ff || rsp_ready;
      if (result.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.emit) begin
         beat_ff <= result.beat;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

// ===== rtl/core/ascii_can_frame_parser_core.sv =====
// top level of the ascii can frame parser: input register, parser, result register
//
//   channel   dir   beat contents
//   req_ch    in    char_in, one received character
//   rsp_ch    out   frame header fields plus one data byte, last and error marks
//
// a character waits in the input register, then is parsed and its beat, if any, lands in
// the result register; one character per cycle sustained while rsp is not stalled.
// synchronous reset returns the parser to idle and empties both registers.
// a stalled rsp holds the input register, and req_ready drops once that is full.
module ascii_can_frame_parser_core (
   input logic        clock,
   input logic        reset,
   acfp_req_if.sink   req_ch,
   acfp_rsp_if.source rsp_ch
);
   import acfp_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    char_ff;
   logic          advance;
   logic          space;
   logic          take;
   parse_out_type result;
   rsp_type       beat;

   assign advance      = in_valid_ff && space;
   assign req_ch.ready = !in_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= req_ch.char_in;
      end
   end

   acfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .char_in (char_ff),
      .result  (result)
   );

   acfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .rsp_ready (rsp_ch.ready),
      .space     (space),
      .rsp_valid (rsp_ch.valid),
      .rsp_beat  (beat)
   );

   assign rsp_ch.frame_letter = beat.frame_letter;
   assign rsp_ch.extended     = beat.extended;
   assign rsp_ch.ident        = beat.ident;
   assign rsp_ch.dlc_code     = beat.dlc_code;
   assign rsp_ch.payload_len  = beat.payload_len;
   assign rsp_ch.byte_index   = beat.byte_index;
   assign rsp_ch.data_byte    = beat.data_byte;
   assign rsp_ch.has_data     = beat.has_data;
   assign rsp_ch.last         = beat.last;
   assign rsp_ch.bad_digit    = beat.bad_digit;

endmodule

// ===== tb/sv/ascii_can_frame_parser_core_test.sv =====
// self-checking testbench of the ascii can frame parser core: directed rows then random frames and stray characters
module ascii_can_frame_parser_core_test;
   import acfp_pkg::*;

   typedef struct {
      logic [7:0] ch;
      bit         typed;
      rsp_type    exp;
   } char_row_type;

   localparam int unsigned CHAR_TARGET = 1300;
   localparam int unsigned HOLD_AT     = 500;
   localparam int unsigned HOLD_CYCLES = 300;

   localparam logic [6:0] FD_LENGTHS [16] = '{
      7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
      7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48, 7'd64
   };

   logic clock;
   logic reset;

   acfp_req_if req_ch ();
   acfp_rsp_if rsp_ch ();

   ascii_can_frame_parser_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // parser shadow state
   phase_type   ph;
   logic [3:0]  digit_cnt;
   logic [31:0] ident_sum;
   logic [7:0]  type_char;
   logic        ext_frame;
   logic [3:0]  dlc_val;
   logic [6:0]  bytes_done;
   logic [3:0]  hi_nib;
   logic        digit_err;

   char_row_type stim_q[$];
   rsp_type      parsed_q[$];

   int unsigned sent_chars = 0;
   int unsigned n_frames   = 0;
   int unsigned n_beats    = 0;
   int unsigned n_headers  = 0;
   int unsigned n_flagged  = 0;
   int unsigned fail_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("ascii_can_frame_parser_core: mismatch");
      $finish;
   end

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      digit_err = 1'b1;
      return 4'd0;
   endfunction

   task automatic parse_char(input logic [7:0] c, output bit got, output rsp_type beat);
      logic [3:0] v;
      logic [5:0] idx;
      logic [7:0] data;
      logic       has;
      logic       fin;
      got  = 1'b0;
      beat = '0;
      idx  = '0;
      data = '0;
      has  = 1'b0;
      fin  = 1'b0;
      case (ph)
         PH_IDLE: begin
            if (c != CHAR_CR) begin
               type_char  = c;
               ext_frame  = (c > CHAR_UPPER_A) && (c < CHAR_UPPER_Z);
               ident_sum  = '0;
               digit_cnt  = '0;
               digit_err  = 1'b0;
               dlc_val    = '0;
               bytes_done = '0;
               hi_nib     = '0;
               ph         = PH_ID;
            end
         end
         PH_ID: begin
            v         = nibble_of(c);
            ident_sum = {ident_sum[27:0], v};
            digit_cnt = digit_cnt + 4'd1;
            if (digit_cnt >= (ext_frame ? ID_DIGITS_EXT : ID_DIGITS_STD)) ph = PH_DLC;
         end
         PH_DLC: begin
            dlc_val    = nibble_of(c);
            bytes_done = '0;
            digit_cnt  = '0;
            if (FD_LENGTHS[dlc_val] == 7'd0) begin
               got = 1'b1;
               fin = 1'b1;
               ph  = PH_IDLE;
            end else begin
               ph = PH_DATA;
            end
         end
         default: begin
            v = nibble_of(c);
            if (digit_cnt == 4'd0) begin
               hi_nib    = v;
               digit_cnt = 4'd1;
            end else begin
               digit_cnt  = 4'd0;
               got        = 1'b1;
               idx        = bytes_done[5:0];
               data       = {hi_nib, v};
               has        = 1'b1;
               fin        = (int'(bytes_done) + 1 >= int'(FD_LENGTHS[dlc_val]));
               bytes_done = bytes_done + 7'd1;
               if (fin) ph = PH_IDLE;
            end
         end
      endcase
      if (got) begin
         beat.frame_letter = type_char;
         beat.extended     = ext_frame;
         beat.ident        = ident_sum;
         beat.dlc_code     = dlc_val;
         beat.payload_len  = FD_LENGTHS[dlc_val];
         beat.byte_index   = idx;
         beat.data_byte    = data;
         beat.has_data     = has;
         beat.last         = fin;
         beat.bad_digit    = digit_err;
      end
   endtask

   function automatic rsp_type mk_rsp(input logic [7:0] letter, input logic ext,
                                      input logic [31:0] ident, input logic [3:0] dlc,
                                      input logic [6:0] len, input logic [5:0] idx,
                                      input logic [7:0] data, input logic has,
                                      input logic fin, input logic bad);
      rsp_type r;
      r.frame_letter = letter;
      r.extended     = ext;
      r.ident        = ident;
      r.dlc_code     = dlc;
      r.payload_len  = len;
      r.byte_index   = idx;
      r.data_byte    = data;
      r.has_data     = has;
      r.last         = fin;
      r.bad_digit    = bad;
      return r;
   endfunction

   task automatic add_row(input logic [7:0] c, input bit typed = 1'b0,
                          input rsp_type exp = '0);
      char_row_type row;
      row.ch    = c;
      row.typed = typed;
      row.exp   = exp;
      stim_q.push_back(row);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'("0" + v);
      return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 4'd10);
   endfunction

   function automatic logic [7:0] digit_char();
      int unsigned r = $urandom_range(0, 99);
      if (r < 2) return 8'($urandom);
      if (r == 2) return CHAR_CR;
      return hex_char(4'($urandom));
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic add_frame();
      int unsigned r;
      int unsigned n_id;
      logic [7:0]  letter;
      logic [3:0]  dlc;
      r = $urandom_range(0, 99);
      if (r < 45) letter = 8'($urandom_range(8'h42, 8'h59));
      else if (r < 55) letter = $urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_UPPER_Z;
      else if (r < 75) letter = 8'($urandom_range(8'h61, 8'h7A));
      else letter = 8'($urandom);
      n_id = (letter > CHAR_UPPER_A && letter < CHAR_UPPER_Z) ? ID_DIGITS_EXT : ID_DIGITS_STD;
      add_row(letter);
      repeat (n_id) add_row(digit_char());
      r = $urandom_range(0, 99);
      if (r < 15) dlc = 4'd0;
      else if (r < 75) dlc = 4'($urandom_range(1, 8));
      else if (r < 95) dlc = 4'($urandom_range(9, 12));
      else dlc = 4'($urandom_range(13, 15));
      if ($urandom_range(0, 49) == 0) add_row(8'($urandom));
      else add_row(hex_char(dlc));
      repeat (2 * FD_LENGTHS[dlc]) add_row(digit_char());
      if ($urandom_range(0, 1) == 1) add_row(CHAR_CR);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp,
                              input logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected %0h, got %0h", name, exp, act);
         fail_count++;
      end
   endtask

   initial begin
      char_row_type row;
      bit           got;
      rsp_type      beat;
      int unsigned  gap;
      int unsigned  n_directed;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.char_in <= 8'h00;
      ph         = PH_IDLE;
      digit_cnt  = '0;
      ident_sum  = '0;
      type_char  = '0;
      ext_frame  = 1'b0;
      dlc_val    = '0;
      bytes_done = '0;
      hi_nib     = '0;
      digit_err  = 1'b0;

      add_row(CHAR_CR);
      add_row("A");
      add_row("7");
      add_row("F");
      add_row("f");
      add_row("0", 1'b1, mk_rsp(CHAR_UPPER_A, 1'b0, 32'h0000_07FF, 4'd0, 7'd0, 6'd0,
                                8'h00, 1'b0, 1'b1, 1'b0));
      add_row("Y");
      repeat (8) add_row("f");
      add_row("1");
      add_row("a");
      add_row("F", 1'b1, mk_rsp("Y", 1'b1, 32'hFFFF_FFFF, 4'd1, 7'd1, 6'd0,
                                8'hAF, 1'b1, 1'b1, 1'b0));
      add_row(CHAR_UPPER_Z);
      add_row(8'h00);
      add_row(8'hFF);
      add_row(CHAR_CR);
      add_row("x", 1'b1, mk_rsp(CHAR_UPPER_Z, 1'b0, 32'h0000_0000, 4'd0, 7'd0, 6'd0,
                                8'h00, 1'b0, 1'b1, 1'b1));
      n_frames   = 3;
      n_directed = stim_q.size();
      while (stim_q.size() < n_directed + CHAR_TARGET) begin
         if ($urandom_range(0, 24) == 0) begin
            repeat ($urandom_range(1, 6)) add_row(8'($urandom));
         end else begin
            add_frame();
            n_frames++;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim_q.size(); i++) begin
         row = stim_q[i];
         gap = ((i / 150) % 4 == 2) ? 0 : pick_gap();
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_ch.valid   <= 1'b1;
         req_ch.char_in <= row.ch;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         sent_chars++;
         parse_char(row.ch, got, beat);
         if (row.typed) parsed_q.push_back(row.exp);
         else if (got) parsed_q.push_back(beat);
      end
      req_ch.valid <= 1'b0;

      while (parsed_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d characters in %0d frames, receiver held off %0d cycles once",
               sent_chars, n_frames, HOLD_CYCLES);
      $display("%0d beats checked: %0d header-only, %0d with a bad digit",
               n_beats, n_headers, n_flagged);
      if (fail_count == 0) begin
         $display("ascii_can_frame_parser_core: match");
      end else begin
         $display("ascii_can_frame_parser_core: mismatch");
      end
      $finish;
   end

   initial begin
      int unsigned stall;
      bit          hold_done;
      hold_done     = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_ch.ready <= 1'b1;
      forever begin
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!hold_done && sent_chars >= HOLD_AT) begin
            stall     = HOLD_CYCLES;
            hold_done = 1'b1;
         end else if ((sent_chars / 150) % 4 == 0) begin
            stall = 0;
         end else begin
            stall = pick_gap();
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (parsed_q.size() == 0) begin
            $error("beat with nothing expected: letter %0h ident %0h byte %0h",
                   rsp_ch.frame_letter, rsp_ch.ident, rsp_ch.data_byte);
            fail_count++;
         end else begin
            want = parsed_q.pop_front();
            check_field("frame_letter", want.frame_letter, rsp_ch.frame_letter);
            check_field("extended", want.extended, rsp_ch.extended);
            check_field("ident", want.ident, rsp_ch.ident);
            check_field("dlc_code", want.dlc_code, rsp_ch.dlc_code);
            check_field("payload_len", want.payload_len, rsp_ch.payload_len);
            check_field("byte_index", want.byte_index, rsp_ch.byte_index);
            check_field("data_byte", want.data_byte, rsp_ch.data_byte);
            check_field("has_data", want.has_data, rsp_ch.has_data);
            check_field("last", want.last, rsp_ch.last);
            check_field("bad_digit", want.bad_digit, rsp_ch.bad_digit);
            n_beats++;
            if (!want.has_data) n_headers++;
            if (want.bad_digit) n_flagged++;
         end
      end
   end

endmodule

// ===== filelist.f =====
rtl/core/acfp_pkg.sv
rtl/core/acfp_if.sv
rtl/core/acfp_parser.sv
rtl/core/acfp_out_reg.sv
rtl/core/ascii_can_frame_parser_core.sv
tb/sv/ascii_can_frame_parser_core_test.sv
